@@ rtl/core/jesc_pkg.sv @@
// Shared types, constants and register codes for the Julia escape-time pixel block.
package jesc_pkg;

   // Q4.28 coordinates and full-width products
   localparam int COORD_W    = 32;
   localparam int FRAC_W     = 28;
   localparam int PROD_W     = 2 * COORD_W;
   localparam logic [PROD_W-1:0] ESCAPE_RADIUS_SQ = PROD_W'(2 * 2) << (2 * FRAC_W);

   // Stream fields
   localparam int PIXEL_W    = 10;
   localparam int COUNT_W    = 16;
   localparam int HUE_BASE_W = 9;
   localparam int HUE_W      = 10;
   localparam int REQ_DATA_W = ((2 * PIXEL_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((COUNT_W + HUE_W + 7) / 8) * 8;

   // Hue scaling: count * 360 / limit
   localparam int HUE_CIRCLE = 360;
   localparam int QUOT_W     = $clog2(HUE_CIRCLE + 1);
   localparam int HUE_MUL_W  = COUNT_W + QUOT_W;

   localparam int DEFAULT_IMAGE_WIDTH  = 1024;
   localparam int DEFAULT_IMAGE_HEIGHT = 1024;

   // Register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_VIEW_LEFT   = 3'd0,
      REG_VIEW_RIGHT  = 3'd1,
      REG_VIEW_TOP    = 3'd2,
      REG_VIEW_BOTTOM = 3'd3,
      REG_CONST_REAL  = 3'd4,
      REG_CONST_IMAG  = 3'd5,
      REG_ITER_LIMIT  = 3'd6,
      REG_HUE_BASE    = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] view_left;
      logic signed [COORD_W-1:0] view_right;
      logic signed [COORD_W-1:0] view_top;
      logic signed [COORD_W-1:0] view_bottom;
      logic signed [COORD_W-1:0] const_real;
      logic signed [COORD_W-1:0] const_imag;
      logic [COUNT_W-1:0]        iteration_limit;
      logic [HUE_BASE_W-1:0]     hue_base;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      view_left:       -32'sd402653184,
      view_right:      32'sd402653184,
      view_top:        -32'sd268435456,
      view_bottom:     32'sd268435456,
      const_real:      -32'sd214748365,
      const_imag:      32'sd41875931,
      iteration_limit: 16'd255,
      hue_base:        9'd0
   };

   // Controller to datapath
   typedef struct packed {
      logic capture;     // multiply spans by pixel indexes, clear count
      logic map_add;     // shift, offset and saturate start point
      logic square;      // register re*re, im*im, re*im
      logic step;        // write z^2 + c, advance count
      logic div_start;   // launch hue divide
      logic out_load;    // load result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic limit_reached;
      logic limit_zero;
      logic escaped;
      logic div_done;
   } dp_sts_type;

endpackage

@@ rtl/core/jesc_csr.sv @@
// Configuration register file: viewport, Julia constant, iteration limit and hue base.
module jesc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jesc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jesc_pkg::CSR_DATA_W-1:0]  csr_data,
   output jesc_pkg::cfg_type                cfg
);
   import jesc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_VIEW_LEFT:   cfg_in.view_left       = $signed(csr_data[COORD_W-1:0]);
            REG_VIEW_RIGHT:  cfg_in.view_right      = $signed(csr_data[COORD_W-1:0]);
            REG_VIEW_TOP:    cfg_in.view_top        = $signed(csr_data[COORD_W-1:0]);
            REG_VIEW_BOTTOM: cfg_in.view_bottom     = $signed(csr_data[COORD_W-1:0]);
            REG_CONST_REAL:  cfg_in.const_real      = $signed(csr_data[COORD_W-1:0]);
            REG_CONST_IMAG:  cfg_in.const_imag      = $signed(csr_data[COORD_W-1:0]);
            REG_ITER_LIMIT:  cfg_in.iteration_limit = csr_data[COUNT_W-1:0];
            REG_HUE_BASE:    cfg_in.hue_base        = csr_data[HUE_BASE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

@@ rtl/core/jesc_div.sv @@
// Restoring divider for the hue scale: one quotient bit per cycle.
module jesc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [jesc_pkg::HUE_MUL_W-1:0] dividend,
   input  logic [jesc_pkg::COUNT_W-1:0]   divisor,
   output logic                           done,
   output logic [jesc_pkg::QUOT_W-1:0]    quotient
);
   import jesc_pkg::*;

   localparam int STEP_W = $clog2(HUE_MUL_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   dvsr_ff, dvsr_in;
   logic [HUE_MUL_W-1:0] quo_ff, quo_in;
   logic [COUNT_W:0]     shifted;
   logic [COUNT_W+1:0]   trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[HUE_MUL_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvsr_in = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // keep the shifted remainder when the trial subtract goes negative
         quo_in  = {quo_ff[HUE_MUL_W-2:0], ~trial[COUNT_W+1]};
         rem_in  = trial[COUNT_W+1] ? shifted[COUNT_W-1:0] : trial[COUNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(HUE_MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[QUOT_W-1:0];

   assert property (@(posedge clock) disable iff (reset)
      start |-> ##(HUE_MUL_W + 1) done)
      else $error("divider did not finish on schedule");

   assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff)
      else $error("divider reports done while still busy");

endmodule

@@ rtl/core/jesc_dp.sv @@
// Datapath: viewport mapping, z^2 + c iteration, escape test, hue scaling, result register.
module jesc_dp #(
   parameter int IMAGE_WIDTH  = jesc_pkg::DEFAULT_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = jesc_pkg::DEFAULT_IMAGE_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  jesc_pkg::cfg_type            cfg,
   input  jesc_pkg::dp_cmd_type         cmd,
   output jesc_pkg::dp_sts_type         sts,
   input  logic [jesc_pkg::PIXEL_W-1:0] pixel_col,
   input  logic [jesc_pkg::PIXEL_W-1:0] pixel_row,
   output logic [jesc_pkg::COUNT_W-1:0] escape_count,
   output logic [jesc_pkg::HUE_W-1:0]   hue_degrees
);
   import jesc_pkg::*;

   localparam int COL_SHIFT = $clog2(IMAGE_WIDTH);
   localparam int ROW_SHIFT = $clog2(IMAGE_HEIGHT);
   localparam int SPAN_W    = COORD_W + 1;
   localparam int MAP_W     = SPAN_W + PIXEL_W + 1;
   localparam int SAT_W     = MAP_W;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
      logic fits;
      fits = (&v[SAT_W-1:COORD_W-1]) || !(|v[SAT_W-1:COORD_W-1]);
      if (fits) begin
         return v[COORD_W-1:0];
      end else if (v[SAT_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   logic signed [SPAN_W-1:0]  span_re, span_im;
   logic signed [MAP_W-1:0]   map_re_ff, map_re_in, map_im_ff, map_im_in;
   logic signed [SAT_W-1:0]   start_re, start_im;
   logic signed [COORD_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [PROD_W-1:0]  rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic signed [PROD_W-1:0]  rr_minus_ii;
   logic signed [SAT_W-1:0]   next_re, next_im;
   logic [PROD_W-1:0]         mag;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        escape_count_ff;
   logic [HUE_W-1:0]          hue_ff;
   logic [HUE_MUL_W-1:0]      dividend;
   logic [QUOT_W-1:0]         quotient;
   logic                      div_done;

   always_comb begin
      // start point: lo + floor(span * index / 2^clog2(size))
      span_re   = $signed({cfg.view_right[COORD_W-1], cfg.view_right})
                - $signed({cfg.view_left[COORD_W-1], cfg.view_left});
      span_im   = $signed({cfg.view_bottom[COORD_W-1], cfg.view_bottom})
                - $signed({cfg.view_top[COORD_W-1], cfg.view_top});
      map_re_in = MAP_W'(span_re) * MAP_W'($signed({1'b0, pixel_col}));
      map_im_in = MAP_W'(span_im) * MAP_W'($signed({1'b0, pixel_row}));
      start_re  = (map_re_ff >>> COL_SHIFT) + SAT_W'(cfg.view_left);
      start_im  = (map_im_ff >>> ROW_SHIFT) + SAT_W'(cfg.view_top);

      rr_in = PROD_W'(re_ff) * PROD_W'(re_ff);
      ii_in = PROD_W'(im_ff) * PROD_W'(im_ff);
      ri_in = PROD_W'(re_ff) * PROD_W'(im_ff);

      mag         = $unsigned(rr_ff) + $unsigned(ii_ff);
      rr_minus_ii = rr_ff - ii_ff;
      next_re     = SAT_W'(rr_minus_ii >>> FRAC_W) + SAT_W'(cfg.const_real);
      next_im     = SAT_W'(ri_ff >>> (FRAC_W - 1)) + SAT_W'(cfg.const_imag);

      re_in    = re_ff;
      im_in    = im_ff;
      count_in = count_ff;
      if (cmd.capture) begin
         count_in = '0;
      end
      if (cmd.map_add) begin
         re_in = sat_coord(start_re);
         im_in = sat_coord(start_im);
      end
      if (cmd.step) begin
         re_in    = sat_coord(next_re);
         im_in    = sat_coord(next_im);
         count_in = count_ff + 1'b1;
      end

      dividend = HUE_MUL_W'(count_ff) * HUE_MUL_W'(HUE_CIRCLE);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         map_re_ff <= map_re_in;
         map_im_ff <= map_im_in;
      end
      if (cmd.square) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      re_ff    <= re_in;
      im_ff    <= im_in;
      count_ff <= count_in;
      if (cmd.out_load) begin
         escape_count_ff <= count_ff;
         hue_ff <= (sts.limit_zero ? HUE_W'(0) : HUE_W'(quotient)) + HUE_W'(cfg.hue_base);
      end
   end

   jesc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (cfg.iteration_limit),
      .done     (div_done),
      .quotient (quotient)
   );

   assign sts.limit_reached = count_ff >= cfg.iteration_limit;
   assign sts.limit_zero    = cfg.iteration_limit == '0;
   assign sts.escaped       = mag > ESCAPE_RADIUS_SQ;
   assign sts.div_done      = div_done;

   assign escape_count = escape_count_ff;
   assign hue_degrees  = hue_ff;

endmodule

@@ rtl/core/jesc_ctrl.sv @@
// Controller: sequences map, iterate, hue divide and result hand-off for one pixel.
module jesc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output jesc_pkg::dp_cmd_type cmd,
   input  jesc_pkg::dp_sts_type sts
);
   import jesc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_SQUARE,
      ST_UPDATE,
      ST_HUE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map_add = 1'b1;
            state_in    = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (sts.limit_reached) begin
               state_in = ST_HUE;
            end else begin
               cmd.square = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (sts.escaped) begin
               state_in = ST_HUE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_HUE: begin
            // zero limit: skip the divide, hue is the base alone
            if (sts.limit_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while a pixel is in flight");

   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.limit_zero)
      else $error("hue divide launched with zero divisor");

   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !sts.escaped && !sts.limit_reached)
      else $error("iteration advanced past escape or limit");

endmodule

@@ rtl/core/julia_escape_time_pixel.sv @@
// Each z^2 + c iteration passes through the squaring and update stages; on escape or at the
// iteration limit a 25-step bit-serial hue divide follows, skipped when the limit is zero.
// Throughput: one pixel at a time; the next request is taken the cycle after the result
// moves to the output register, while that result waits for rsp_tready.
// Reset: synchronous, active high; config registers return to defaults, no result pending.
module julia_escape_time_pixel #(
   parameter int IMAGE_WIDTH  = jesc_pkg::DEFAULT_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = jesc_pkg::DEFAULT_IMAGE_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [jesc_pkg::REQ_DATA_W-1:0]  req_tdata,   // pixel_col, pixel_row, zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [jesc_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // escape_count, hue_degrees, zero pad
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jesc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jesc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import jesc_pkg::*;

   cfg_type            cfg;
   dp_cmd_type         cmd;
   dp_sts_type         sts;
   logic [COUNT_W-1:0] escape_count;
   logic [HUE_W-1:0]   hue_degrees;

   jesc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   jesc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   jesc_dp #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .sts          (sts),
      .pixel_col    (req_tdata[PIXEL_W-1:0]),
      .pixel_row    (req_tdata[2*PIXEL_W-1:PIXEL_W]),
      .escape_count (escape_count),
      .hue_degrees  (hue_degrees)
   );

   assign rsp_tdata = RSP_DATA_W'({hue_degrees, escape_count});

endmodule
